// ----- hw/rtl/trimmed_mean_lowpass_filter_assert.svh -----
// Assertion macros for the trimmed mean low-pass filter.
`ifndef TRIMMED_MEAN_LOWPASS_FILTER_ASSERT_SVH
`define TRIMMED_MEAN_LOWPASS_FILTER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define TMLPF_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trimmed mean filter check failed");

// Check cons in the cycle after ante.
`define TMLPF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trimmed mean filter check failed");

`endif

// ----- hw/rtl/tmlpf_pkg.sv -----
// Types and constants of the trimmed mean low-pass filter.
package tmlpf_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned DIV_W    = 19;

  localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;
  localparam int unsigned      TRIM         = 2;

  // floor(x / 100) == (x * PCT_RECIP) >> PCT_SHIFT for every x below 2**DIV_W
  localparam int unsigned            PCT_SHIFT   = 26;
  localparam int unsigned            PCT_RECIP_W = 20;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP   = 20'd671089;

  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  localparam logic REG_SMOOTHING = 1'b0;

  typedef struct packed {
    logic                opcode;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   out_channel;
    logic [SAMPLE_W-1:0] trimmed_mean;
    logic [SAMPLE_W-1:0] filtered_level;
  } out_item_t;

endpackage

// ----- hw/rtl/trimmed_mean_lowpass_filter.sv -----
// Trimmed mean and first-order low-pass filter over per-channel sample windows.
//
//   port group   dir   handshake            payload
//   in           in    in_valid/in_ready    in_item_i  (opcode, channel, sample)
//   out          out   out_valid/out_ready  out_item_o (out_channel, trimmed_mean, filtered_level)
//   apb          in    psel/penable/pready  paddr, pwdata, prdata (smoothing_percent)
//
// A store item writes the window memory at the channel's slot.
// A filter item reads its window through the single read port, then passes through the trim,
// mean, multiply, percent scaling and finish steps; finish waits until the output register is
// free, and the next item is accepted in the cycle after the result loads.
// Reset clears the window valid bits, slots, levels and sets the percent to 100.
// A finished result holds in the output register; a new result waits for it to drain.
`include "trimmed_mean_lowpass_filter_assert.svh"

module trimmed_mean_lowpass_filter #(
  parameter int unsigned WINDOW   = 8,
  parameter int unsigned CHANNELS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tmlpf_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tmlpf_pkg::out_item_t out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned SW        = tmlpf_pkg::SAMPLE_W;
  localparam int unsigned PW        = tmlpf_pkg::PCT_W;
  localparam int unsigned DW        = tmlpf_pkg::DIV_W;
  localparam int unsigned RW        = tmlpf_pkg::PCT_RECIP_W;
  localparam int unsigned PrdW      = DW + RW;
  localparam int unsigned Depth     = CHANNELS * WINDOW;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned SlotW     = $clog2(WINDOW);
  localparam int unsigned CntW      = $clog2(WINDOW + 1);
  localparam int unsigned ChIdxW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SumW      = $clog2(WINDOW) + SW;
  localparam int unsigned MeanDiv   = WINDOW - 2 * tmlpf_pkg::TRIM;
  localparam int unsigned MeanShift = SumW + $clog2(MeanDiv);
  localparam int unsigned MeanRecip = ((1 << MeanShift) + MeanDiv - 1) / MeanDiv;
  localparam int unsigned MeanPrdW  = SumW + MeanShift + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_DIVM,
    ST_MUL,
    ST_DIVS,
    ST_FINISH
  } state_e;

  state_e                 state_q;
  logic [tmlpf_pkg::CHAN_W-1:0] ch_q;
  logic [CntW-1:0]        idx_q;
  logic                   acc_en_q;
  logic [SumW-1:0]        sum_q;
  logic [SW-1:0]          max1_q, max2_q, min1_q, min2_q;
  logic [DW-1:0]          quo_q;
  logic [SW-1:0]          mean_q;
  logic                   dn_q;
  logic [PW-1:0]          pct_q;
  logic                   out_valid_q;
  tmlpf_pkg::out_item_t   out_q;
  logic [SlotW-1:0]       slot_q [CHANNELS];
  logic [SW-1:0]          level_q [CHANNELS];
  logic [Depth-1:0]       win_vld_q;

  logic [SW-1:0]          win_mem [Depth];
  logic [SW-1:0]          rdata_q;
  logic                   rvld_q;

  logic                   in_fire;
  logic                   in_ch_ok;
  logic [ChIdxW-1:0]      in_ch_idx;
  logic [ChIdxW-1:0]      ch_idx;
  logic                   store_we;
  logic                   filter_go;
  logic [AddrW-1:0]       waddr;
  logic [AddrW-1:0]       raddr;
  logic                   rd_en;
  logic [SW-1:0]          smp;
  logic [SumW-1:0]        trim_sum;
  logic [MeanPrdW-1:0]    mean_prod;
  logic [PrdW-1:0]        pct_prod;
  logic [SW-1:0]          lvl_cur;
  logic [SW-1:0]          mean_cur;
  logic                   mul_lt;
  logic [SW-1:0]          diff;
  logic [PW-1:0]          pct_eff;
  logic [DW-1:0]          prod;
  logic [SW-1:0]          step;
  logic [SW-1:0]          lvl_new;
  logic                   out_free;
  logic                   out_load;
  logic                   cfg_we;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == tmlpf_pkg::REG_SMOOTHING) ? 32'(pct_q) : 32'd0;
  assign cfg_we      = psel && penable && pwrite && pready &&
                       (paddr[2] == tmlpf_pkg::REG_SMOOTHING);

  always_comb begin
    in_fire   = in_valid_i && in_ready_o;
    in_ch_ok  = (32'(in_item_i.channel) < CHANNELS);
    in_ch_idx = ChIdxW'(in_item_i.channel);
    ch_idx    = ChIdxW'(ch_q);
    store_we  = in_fire && in_ch_ok && (in_item_i.opcode == tmlpf_pkg::OP_STORE);
    filter_go = in_fire && in_ch_ok && (in_item_i.opcode == tmlpf_pkg::OP_FILTER);
    waddr     = AddrW'(32'(in_ch_idx) * WINDOW + 32'(slot_q[in_ch_idx]));
    raddr     = AddrW'(32'(ch_idx) * WINDOW + 32'(idx_q[SlotW-1:0]));
    rd_en     = (state_q == ST_SCAN) && (idx_q != CntW'(WINDOW));
    smp       = rvld_q ? rdata_q : '0;

    trim_sum = sum_q - (SumW'(max1_q) + SumW'(max2_q) + SumW'(min1_q) + SumW'(min2_q));

    mean_prod = MeanPrdW'(quo_q[SumW-1:0]) * MeanPrdW'(MeanRecip);
    pct_prod  = PrdW'(quo_q) * PrdW'(tmlpf_pkg::PCT_RECIP);

    lvl_cur  = level_q[ch_idx];
    mean_cur = quo_q[SW-1:0];
    mul_lt   = (mean_cur < lvl_cur);
    diff     = mul_lt ? (lvl_cur - mean_cur) : (mean_cur - lvl_cur);
    pct_eff  = (pct_q > tmlpf_pkg::PERCENT_FULL) ? tmlpf_pkg::PERCENT_FULL : pct_q;
    prod     = DW'(diff) * DW'(pct_eff);

    step     = quo_q[SW-1:0];
    lvl_new  = dn_q ? (lvl_cur - step) : (lvl_cur + step);
    out_free = !out_valid_q || out_ready_i;
    out_load = (state_q == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      win_mem[waddr] <= in_item_i.sample;
    end
    if (rd_en) begin
      rdata_q <= win_mem[raddr];
      rvld_q  <= win_vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      idx_q       <= '0;
      acc_en_q    <= 1'b0;
      sum_q       <= '0;
      max1_q      <= '0;
      max2_q      <= '0;
      min1_q      <= '0;
      min2_q      <= '0;
      quo_q       <= '0;
      mean_q      <= '0;
      dn_q        <= 1'b0;
      pct_q       <= tmlpf_pkg::PERCENT_FULL;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      win_vld_q   <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        slot_q[c]  <= '0;
        level_q[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        pct_q <= pwdata[PW-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (store_we) begin
        win_vld_q[waddr] <= 1'b1;
        slot_q[in_ch_idx] <= (slot_q[in_ch_idx] == SlotW'(WINDOW - 1)) ? '0 :
                             slot_q[in_ch_idx] + 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (filter_go) begin
            ch_q     <= in_item_i.channel;
            idx_q    <= '0;
            acc_en_q <= 1'b0;
            sum_q    <= '0;
            max1_q   <= '0;
            max2_q   <= '0;
            min1_q   <= '1;
            min2_q   <= '1;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          acc_en_q <= rd_en;
          if (rd_en) begin
            idx_q <= idx_q + 1'b1;
          end
          if (acc_en_q) begin
            sum_q <= sum_q + SumW'(smp);
            if (smp > max1_q) begin
              max1_q <= smp;
              max2_q <= max1_q;
            end else if (smp > max2_q) begin
              max2_q <= smp;
            end
            if (smp < min1_q) begin
              min1_q <= smp;
              min2_q <= min1_q;
            end else if (smp < min2_q) begin
              min2_q <= smp;
            end
            if (!rd_en) begin
              state_q <= ST_TRIM;
            end
          end
        end
        ST_TRIM: begin
          quo_q   <= DW'(trim_sum);
          state_q <= ST_DIVM;
        end
        ST_DIVM: begin
          quo_q   <= DW'(mean_prod[MeanShift +: SW]);
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          mean_q  <= mean_cur;
          dn_q    <= mul_lt;
          quo_q   <= prod;
          state_q <= ST_DIVS;
        end
        ST_DIVS: begin
          quo_q   <= DW'(pct_prod[tmlpf_pkg::PCT_SHIFT +: SW]);
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            level_q[ch_idx]      <= lvl_new;
            out_q.out_channel    <= ch_q;
            out_q.trimmed_mean   <= mean_q;
            out_q.filtered_level <= lvl_new;
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `TMLPF_ASSERT_NEXT(a_filter_starts_scan, filter_go, (state_q == ST_SCAN) && (idx_q == '0))
  `TMLPF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))
  `TMLPF_ASSERT_SAME(a_trim_order, state_q == ST_TRIM, (max1_q >= max2_q) && (min1_q <= min2_q) && (min2_q <= max2_q))

endmodule

// ----- tb/trimmed_mean_lowpass_filter_tb.sv -----
// Self-checking testbench for the trimmed mean low-pass filter with random traffic and stalls.
`timescale 1ns / 1ps

module trimmed_mean_lowpass_filter_tb;

  localparam int unsigned WINDOW      = 8;
  localparam int unsigned CHANNELS    = 4;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 205;
  localparam int unsigned SETTLE      = WINDOW + 60;
  localparam int unsigned SW          = tmlpf_pkg::SAMPLE_W;
  localparam int unsigned CW          = tmlpf_pkg::CHAN_W;
  localparam int unsigned PW          = tmlpf_pkg::PCT_W;

  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_RAILS,
    SPREAD_OUTLIERS
  } sample_shape_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                 in_valid_i;
  logic                 in_ready_o;
  tmlpf_pkg::in_item_t  in_item_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  tmlpf_pkg::out_item_t out_item_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  tmlpf_pkg::in_item_t  adc_items_to_send[$];
  tmlpf_pkg::out_item_t pending_filter_results[$];
  logic        in_taken = 1'b0;
  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned filters_seen   = 0;
  int unsigned results_seen   = 0;
  int unsigned error_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  logic [SW-1:0] window_store [CHANNELS][WINDOW];
  int unsigned   slot_ptr [CHANNELS];
  logic [SW-1:0] level_reg [CHANNELS];
  logic [PW-1:0] smoothing_pct;

  trimmed_mean_lowpass_filter #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [SW-1:0] trimmed_window_mean(input int unsigned ch);
    logic [SW-1:0] sorted [WINDOW];
    logic [SW-1:0] v;
    int unsigned i, j, total;
    for (i = 0; i < WINDOW; i++) sorted[i] = window_store[ch][i];
    for (i = 1; i < WINDOW; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    total = 0;
    for (i = tmlpf_pkg::TRIM; i < WINDOW - tmlpf_pkg::TRIM; i++) total += 32'(sorted[i]);
    return SW'(total / (WINDOW - 2 * tmlpf_pkg::TRIM));
  endfunction

  function automatic void store_sample(input tmlpf_pkg::in_item_t item);
    window_store[item.channel][slot_ptr[item.channel]] = item.sample;
    slot_ptr[item.channel] = (slot_ptr[item.channel] + 1) % WINDOW;
  endfunction

  function automatic tmlpf_pkg::out_item_t predict_filter_result(input logic [CW-1:0] ch);
    tmlpf_pkg::out_item_t res;
    int unsigned pct, mean, level, delta;
    pct   = (smoothing_pct > tmlpf_pkg::PERCENT_FULL) ? 32'(tmlpf_pkg::PERCENT_FULL) :
            32'(smoothing_pct);
    mean  = 32'(trimmed_window_mean(32'(ch)));
    level = 32'(level_reg[ch]);
    if (mean < level) begin
      delta = (level - mean) * pct / 32'(tmlpf_pkg::PERCENT_FULL);
      level = level - delta;
    end else begin
      delta = (mean - level) * pct / 32'(tmlpf_pkg::PERCENT_FULL);
      level = level + delta;
    end
    level_reg[ch]      = SW'(level);
    res.out_channel    = ch;
    res.trimmed_mean   = SW'(mean);
    res.filtered_level = SW'(level);
    return res;
  endfunction

  function automatic void push_adc_item(input logic op, input logic [CW-1:0] ch,
                                        input logic [SW-1:0] smp);
    tmlpf_pkg::in_item_t item;
    item.opcode  = op;
    item.channel = ch;
    item.sample  = smp;
    adc_items_to_send.push_back(item);
    items_queued++;
  endfunction

  task automatic queue_random_traffic(input int unsigned quota);
    int unsigned   made, burst, k;
    sample_shape_e shape;
    logic [CW-1:0] ch;
    logic [SW-1:0] base, smp;
    made = 0;
    while (made < quota) begin
      ch = CW'($urandom_range(CHANNELS - 1));
      if ($urandom_range(9) == 0) begin
        push_adc_item(1'($urandom_range(1)), CW'($urandom_range(3)),
                      SW'($urandom_range(4095)));
        made++;
      end else begin
        burst = $urandom_range(WINDOW + 3);
        shape = sample_shape_e'($urandom_range(3));
        base  = SW'($urandom_range(4095));
        for (k = 0; k < burst; k++) begin
          case (shape)
            SPREAD_FULL: smp = SW'($urandom_range(4095));
            SPREAD_NARROW: smp = base ^ SW'($urandom_range(63));
            SPREAD_RAILS: smp = $urandom_range(1) ? 12'hFFF : 12'h000;
            default: begin
              if ($urandom_range(3) == 0) smp = $urandom_range(1) ? 12'hFFF : 12'h000;
              else smp = base ^ SW'($urandom_range(15));
            end
          endcase
          push_adc_item(tmlpf_pkg::OP_STORE, ch, smp);
          made++;
        end
        if ($urandom_range(4) != 0) begin
          push_adc_item(tmlpf_pkg::OP_FILTER, ch, SW'($urandom_range(4095)));
          made++;
        end
      end
    end
  endtask

  task automatic wait_until_drained();
    while (items_accepted != items_queued || pending_filter_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_smoothing(input logic [PW-1:0] pct);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {tmlpf_pkg::REG_SMOOTHING, 2'b00};
    pwdata  <= 32'(pct);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    smoothing_pct = pct;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(pct)) begin
      $error("smoothing_percent readback: expected %0d, actual %0d", pct, prdata);
      error_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk_i) begin : drive_items
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (adc_items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item_i  <= adc_items_to_send.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    tmlpf_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_filter_results.size() == 0) begin
          $error("unexpected filter result: channel %0d mean %0d level %0d",
                 out_item_o.out_channel, out_item_o.trimmed_mean, out_item_o.filtered_level);
          error_count++;
        end else begin
          want = pending_filter_results.pop_front();
          if (out_item_o.out_channel !== want.out_channel) begin
            $error("out_channel: expected %0d, actual %0d",
                   want.out_channel, out_item_o.out_channel);
            error_count++;
          end
          if (out_item_o.trimmed_mean !== want.trimmed_mean) begin
            $error("trimmed_mean: expected %0d, actual %0d",
                   want.trimmed_mean, out_item_o.trimmed_mean);
            error_count++;
          end
          if (out_item_o.filtered_level !== want.filtered_level) begin
            $error("filtered_level: expected %0d, actual %0d",
                   want.filtered_level, out_item_o.filtered_level);
            error_count++;
          end
        end
      end
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        items_accepted++;
        if (32'(in_item_i.channel) < CHANNELS) begin
          if (in_item_i.opcode == tmlpf_pkg::OP_STORE) begin
            store_sample(in_item_i);
          end else begin
            filters_seen++;
            pending_filter_results.push_back(predict_filter_result(in_item_i.channel));
          end
        end
      end
    end
  end

  initial begin : run_limit
    #10ms;
    $display("** trimmed_mean_lowpass_filter: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [PW-1:0] pct_plan [PHASES];
    int unsigned   send_plan [4];
    int unsigned   stall_plan [4];
    logic [SW-1:0] mixed [WINDOW];
    int unsigned   phase, k;
    pct_plan   = '{7'd0, 7'd127, 7'd1, 7'd99, 7'd100, 7'd50, 7'd0, 7'd0};
    send_plan  = '{0, 55, 0, 20};
    stall_plan = '{0, 0, 55, 20};
    mixed      = '{12'd4095, 12'd0, 12'd10, 12'd4095, 12'd20, 12'd0, 12'd30, 12'd40};
    pct_plan[6] = PW'($urandom_range(127));
    pct_plan[7] = PW'($urandom_range(100));

    for (k = 0; k < CHANNELS; k++) begin
      slot_ptr[k]  = 0;
      level_reg[k] = '0;
      for (int unsigned s = 0; s < WINDOW; s++) window_store[k][s] = '0;
    end
    smoothing_pct = tmlpf_pkg::PERCENT_FULL;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    push_adc_item(tmlpf_pkg::OP_FILTER, 2'd2, 12'hFFF);
    push_adc_item(tmlpf_pkg::OP_FILTER, 2'd3, 12'h000);
    for (k = 0; k < WINDOW; k++) push_adc_item(tmlpf_pkg::OP_STORE, 2'd0, 12'hFFF);
    push_adc_item(tmlpf_pkg::OP_FILTER, 2'd0, 12'h000);
    for (k = 0; k < WINDOW; k++) push_adc_item(tmlpf_pkg::OP_STORE, 2'd1, mixed[k]);
    push_adc_item(tmlpf_pkg::OP_FILTER, 2'd1, 12'h555);
    for (k = 0; k < 3; k++) push_adc_item(tmlpf_pkg::OP_STORE, 2'd3, 12'd3000 + 12'(k));
    push_adc_item(tmlpf_pkg::OP_FILTER, 2'd3, 12'hAAA);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_until_drained();
      repeat (SETTLE) @(negedge clk_i);
      write_smoothing(pct_plan[phase]);
      send_idle_pct  = send_plan[phase % 4];
      recv_stall_pct = stall_plan[phase % 4];
      queue_random_traffic(PHASE_ITEMS);
    end

    wait_until_drained();
    repeat (SETTLE) @(negedge clk_i);
    $display("Run covered %0d items, %0d filter requests and %0d results,",
             items_accepted, filters_seen, results_seen);
    $display("over %0d smoothing settings and four idle/stall patterns.", PHASES + 1);
    if (error_count == 0) begin
      $display("** trimmed_mean_lowpass_filter: PASSED **");
    end else begin
      $display("** trimmed_mean_lowpass_filter: FAILED **");
    end
    $finish;
  end

endmodule
